### hdl/irmsm_pkg.sv
// ----------------------------------------------------------------------------
// irmsm_pkg
// Shared types and constants for the infrared mark/space modulator.
// ----------------------------------------------------------------------------
package irmsm_pkg;

  // default counter widths
  localparam int DURATION_BITS_DEF = 16;
  localparam int CARRIER_BITS_DEF  = 16;

  // configuration register widths
  localparam int RELOAD_W   = 16;
  localparam int PRESCALE_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // configuration reset values
  localparam logic [RELOAD_W-1:0]   RELOAD_RST   = 16'd1262;
  localparam logic [PRESCALE_W-1:0] PRESCALE_RST = 8'd48;
  localparam logic                  INVERT_RST   = 1'b1;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CARRIER_RELOAD = 2'd0,
    CFG_CYCLES_PER_US  = 2'd1,
    CFG_OUTPUT_INVERT  = 2'd2
  } cfg_idx_t;

  // request operation codes
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  // configuration seen by the engine
  typedef struct packed {
    logic [RELOAD_W-1:0]   carrier_reload;
    logic [PRESCALE_W-1:0] cycles_per_us;
    logic                  output_invert;
  } cfg_t;

  // one result
  typedef struct packed {
    logic ir_level;
    logic active;
    logic slot_free;
    logic done_res;
    logic underrun;
  } result_t;

endpackage

### hdl/irmsm_engine.sv
// ----------------------------------------------------------------------------
// irmsm_engine
// Modulator state (carrier, prescaler, envelope, current and waiting pair)
// and the single-pass update that produces the result for each request.
// ----------------------------------------------------------------------------
module irmsm_engine
  import irmsm_pkg::*;
#(
  parameter int DURATION_BITS = DURATION_BITS_DEF,
  parameter int CARRIER_BITS  = CARRIER_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic                     operation,
  input  logic [DURATION_BITS-1:0] mark_us,
  input  logic [DURATION_BITS-1:0] space_us,
  input  logic                     last_pair,
  input  cfg_t                     cfg,
  output result_t                  result
);

  localparam int ENV_W = DURATION_BITS + 1;

  logic [CARRIER_BITS-1:0]  car_r, car_nxt;
  logic [PRESCALE_W-1:0]    pre_r, pre_nxt;
  logic [ENV_W-1:0]         env_r, env_nxt, env_tick;
  logic [DURATION_BITS-1:0] cur_mark_r, cur_mark_nxt;
  logic [DURATION_BITS-1:0] cur_space_r, cur_space_nxt;
  logic                     cur_last_r, cur_last_nxt;
  logic [DURATION_BITS-1:0] pend_mark_r, pend_mark_nxt;
  logic [DURATION_BITS-1:0] pend_space_r, pend_space_nxt;
  logic                     pend_last_r, pend_last_nxt;
  logic                     pend_valid_r, pend_valid_nxt;
  logic                     running_r, running_nxt;
  logic                     done_nxt, under_nxt;
  logic [CARRIER_BITS-1:0]  reload_eff;
  logic [ENV_W-1:0]         pair_len;
  logic                     prescale_wrap;
  logic                     carrier_on;

  assign reload_eff    = CARRIER_BITS'(cfg.carrier_reload);
  assign pair_len      = {1'b0, cur_mark_r} + {1'b0, cur_space_r};
  assign prescale_wrap = ({1'b0, pre_r} + 9'd1) >= {1'b0, cfg.cycles_per_us};
  assign env_tick      = prescale_wrap ? env_r + 1'b1 : env_r;

  // next state
  always_comb begin
    car_nxt        = car_r;
    pre_nxt        = pre_r;
    env_nxt        = env_r;
    cur_mark_nxt   = cur_mark_r;
    cur_space_nxt  = cur_space_r;
    cur_last_nxt   = cur_last_r;
    pend_mark_nxt  = pend_mark_r;
    pend_space_nxt = pend_space_r;
    pend_last_nxt  = pend_last_r;
    pend_valid_nxt = pend_valid_r;
    running_nxt    = running_r;
    done_nxt       = 1'b0;
    under_nxt      = 1'b0;
    if (accept) begin
      if (operation == OP_LOAD) begin
        if (!running_r) begin
          // idle: start straight away with cleared counters
          cur_mark_nxt  = mark_us;
          cur_space_nxt = space_us;
          cur_last_nxt  = last_pair;
          env_nxt       = '0;
          car_nxt       = '0;
          pre_nxt       = '0;
          running_nxt   = 1'b1;
        end else if (!pend_valid_r) begin
          pend_mark_nxt  = mark_us;
          pend_space_nxt = space_us;
          pend_last_nxt  = last_pair;
          pend_valid_nxt = 1'b1;
        end
      end else if (running_r) begin
        // carrier wraps at reload
        car_nxt = (car_r >= reload_eff) ? '0 : car_r + 1'b1;
        pre_nxt = prescale_wrap ? '0 : pre_r + 1'b1;
        env_nxt = env_tick;
        // end of pair
        if (env_tick >= pair_len) begin
          if (cur_last_r) begin
            done_nxt       = 1'b1;
            running_nxt    = 1'b0;
            pend_valid_nxt = 1'b0;
          end else if (pend_valid_r) begin
            cur_mark_nxt   = pend_mark_r;
            cur_space_nxt  = pend_space_r;
            cur_last_nxt   = pend_last_r;
            env_nxt        = '0;
            pend_valid_nxt = 1'b0;
          end else begin
            under_nxt   = 1'b1;
            running_nxt = 1'b0;
          end
          if (!running_nxt) begin
            car_nxt = '0;
            pre_nxt = '0;
            env_nxt = '0;
          end
        end
      end
    end
  end

  // result from the updated state
  assign carrier_on = (env_nxt < {1'b0, cur_mark_nxt}) &&
                      (car_nxt < (reload_eff >> 2));

  always_comb begin
    result.ir_level  = running_nxt & (carrier_on ^ cfg.output_invert);
    result.active    = running_nxt;
    result.slot_free = ~pend_valid_nxt;
    result.done_res  = done_nxt;
    result.underrun  = under_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      car_r        <= '0;
      pre_r        <= '0;
      env_r        <= '0;
      cur_last_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      running_r    <= 1'b0;
    end else begin
      car_r        <= car_nxt;
      pre_r        <= pre_nxt;
      env_r        <= env_nxt;
      cur_last_r   <= cur_last_nxt;
      pend_valid_r <= pend_valid_nxt;
      running_r    <= running_nxt;
    end
  end

  // pair payload
  always_ff @(posedge clk) begin
    cur_mark_r   <= cur_mark_nxt;
    cur_space_r  <= cur_space_nxt;
    pend_mark_r  <= pend_mark_nxt;
    pend_space_r <= pend_space_nxt;
    pend_last_r  <= pend_last_nxt;
  end

endmodule

### hdl/irmsm_out_stage.sv
// ----------------------------------------------------------------------------
// irmsm_out_stage
// Result register with valid/stall handshake; frees up whenever the held
// result is taken in the same cycle.
// ----------------------------------------------------------------------------
module irmsm_out_stage
  import irmsm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  result_t result_in,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t result_out
);

  logic    valid_r, valid_nxt;
  result_t result_r;
  logic    load;

  // hold off upstream only while a result is held and not taken
  assign in_stall = valid_r & out_stall;
  assign load     = in_valid & ~in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_in;
    end
  end

  assign out_valid  = valid_r;
  assign result_out = result_r;

endmodule

### hdl/ir_mark_space_modulator_unit.sv
// ----------------------------------------------------------------------------
// ir_mark_space_modulator_unit
// Infrared transmit modulator: carrier at 25% duty during marks, low during
// spaces (inverted by output_invert), with a one-deep slot for the next pair.
// ----------------------------------------------------------------------------
// Every request (one clock tick or one pair load) is taken at once and its
// result appears in the result register on the next cycle, so a request can
// be accepted on every clock unless a held result is stalled. in_stall
// follows out_stall combinationally while a result is held; the only storage
// between the two sides is the one result register. The configuration port
// is always ready; write it only while no transmission is running.
module ir_mark_space_modulator_unit
  import irmsm_pkg::*;
#(
  parameter int DURATION_BITS = DURATION_BITS_DEF,
  parameter int CARRIER_BITS  = CARRIER_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_operation,
  input  logic [DURATION_BITS-1:0] in_mark_us,
  input  logic [DURATION_BITS-1:0] in_space_us,
  input  logic                     in_last_pair,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_ir_level,
  output logic                     out_active,
  output logic                     out_slot_free,
  output logic                     out_done_res,
  output logic                     out_underrun,
  // configuration
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

  cfg_t    cfg_r;
  result_t eng_result;
  result_t out_result;
  logic    accept;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.carrier_reload <= RELOAD_RST;
      cfg_r.cycles_per_us  <= PRESCALE_RST;
      cfg_r.output_invert  <= INVERT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CARRIER_RELOAD: cfg_r.carrier_reload <= cfg_wdata[RELOAD_W-1:0];
        CFG_CYCLES_PER_US:  cfg_r.cycles_per_us  <= cfg_wdata[PRESCALE_W-1:0];
        CFG_OUTPUT_INVERT:  cfg_r.output_invert  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign accept = in_valid & ~in_stall;

  irmsm_engine #(
    .DURATION_BITS (DURATION_BITS),
    .CARRIER_BITS  (CARRIER_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .operation (in_operation),
    .mark_us   (in_mark_us),
    .space_us  (in_space_us),
    .last_pair (in_last_pair),
    .cfg       (cfg_r),
    .result    (eng_result)
  );

  irmsm_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .result_in  (eng_result),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_out (out_result)
  );

  assign out_ir_level  = out_result.ir_level;
  assign out_active    = out_result.active;
  assign out_slot_free = out_result.slot_free;
  assign out_done_res  = out_result.done_res;
  assign out_underrun  = out_result.underrun;

endmodule

### hdl/irmsm_checker.sv
// ----------------------------------------------------------------------------
// irmsm_assertions
// Port-level checks on the modulator result stream, bound to the top level.
// ----------------------------------------------------------------------------
module irmsm_assertions (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_ir_level,
  input logic out_active,
  input logic out_slot_free,
  input logic out_done_res,
  input logic out_underrun
);

  // a held result is not withdrawn
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // pin is low whenever nothing is transmitting
  a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_active |-> !out_ir_level)
    else $error("pin driven while idle");

  // completion and underrun both end the transmission, never together
  a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_done_res || out_underrun) |->
      !out_active && !(out_done_res && out_underrun))
    else $error("end of transmission reported while still active");

  // no pair is left waiting once the block is idle
  a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_active |-> out_slot_free)
    else $error("pending pair kept while idle");

endmodule

bind ir_mark_space_modulator_unit irmsm_assertions u_irmsm_checker (.*);
